// ===== rtl/csim_pkg.sv =====
// Shared constants and types of the cosine similarity engine.
`timescale 1ns / 1ps
package csim_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int MAX_LEN      = 4096;

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int PROD_W = 2 * SAMPLE_WIDTH;
    localparam int NORM_W = PROD_W - 1 + $clog2(MAX_LEN);
    localparam int DOT_W  = NORM_W + 1;
    localparam int MAG_W  = NORM_W;
    localparam int SQ_W   = 2 * MAG_W - 1;
    localparam int ALU_W  = SQ_W + 1;

    localparam int SCALE_SHIFT = 32;
    localparam int QUO_W       = SCALE_SHIFT + 1;
    localparam int RAD_W       = QUO_W + 1;
    localparam int ROOT_W      = RAD_W / 2;
    localparam int SIM_W       = 16;

    localparam int MUL_STEPS  = MAG_W;
    localparam int DIV_STEPS  = QUO_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int STEP_W     = $clog2(MUL_STEPS);

    localparam logic [ROOT_W-1:0] SIM_MAX = ROOT_W'((1 << (SIM_W - 1)) - 1);

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [NORM_W-1:0]       norm_x;
        logic [NORM_W-1:0]       norm_y;
        logic [CNT_W-1:0]        count;
        logic                    done;
    } csim_sums_t;

    typedef struct packed {
        logic signed [SIM_W-1:0] similarity;
        logic                    zero_norm;
        logic [CNT_W-1:0]        element_count;
    } csim_res_t;

endpackage

// ===== rtl/csim_ifs.sv =====
// Valid/ready channel interfaces for element pairs and similarity results.
`timescale 1ns / 1ps
interface csim_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [csim_pkg::SAMPLE_WIDTH-1:0] x_elem;
    logic signed [csim_pkg::SAMPLE_WIDTH-1:0] y_elem;
    logic                                  last_elem;

    modport source (output valid, x_elem, y_elem, last_elem, input ready);
    modport sink (input valid, x_elem, y_elem, last_elem, output ready);
endinterface

interface csim_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [csim_pkg::SIM_W-1:0]  similarity;
    logic                               zero_norm;
    logic [csim_pkg::CNT_W-1:0]         element_count;

    modport source (output valid, similarity, zero_norm, element_count, input ready);
    modport sink (input valid, similarity, zero_norm, element_count, output ready);
endinterface

// ===== rtl/csim_accum.sv =====
// Streaming accumulator of the dot product, both squared norms and the pair count.
`timescale 1ns / 1ps
module csim_accum (
    input  logic                   clk,
    input  logic                   rst_n,
    csim_in_if.sink                elem_ch,
    input  logic                   clear,
    output csim_pkg::csim_sums_t   sums
);
    import csim_pkg::*;

    logic signed [DOT_W-1:0]  dot_reg, dot_next;
    logic [NORM_W-1:0]        nx_reg, nx_next;
    logic [NORM_W-1:0]        ny_reg, ny_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     done_reg, done_next;
    logic signed [PROD_W-1:0] xy_prod;
    logic signed [PROD_W-1:0] xx_prod;
    logic signed [PROD_W-1:0] yy_prod;
    logic                     take;

    assign elem_ch.ready = !done_reg;
    assign take          = elem_ch.valid && !done_reg;

    assign xy_prod = elem_ch.x_elem * elem_ch.y_elem;
    assign xx_prod = elem_ch.x_elem * elem_ch.x_elem;
    assign yy_prod = elem_ch.y_elem * elem_ch.y_elem;

    always_comb
    begin
        dot_next  = dot_reg;
        nx_next   = nx_reg;
        ny_next   = ny_reg;
        cnt_next  = cnt_reg;
        done_next = done_reg;
        if (clear)
        begin
            dot_next  = '0;
            nx_next   = '0;
            ny_next   = '0;
            cnt_next  = '0;
            done_next = 1'b0;
        end
        else if (take)
        begin
            if (cnt_reg < CNT_W'(MAX_LEN))
            begin
                dot_next = dot_reg + DOT_W'(xy_prod);
                nx_next  = nx_reg + NORM_W'($unsigned(xx_prod));
                ny_next  = ny_reg + NORM_W'($unsigned(yy_prod));
                cnt_next = cnt_reg + CNT_W'(1);
            end
            done_next = elem_ch.last_elem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg  <= '0;
            nx_reg   <= '0;
            ny_reg   <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            dot_reg  <= dot_next;
            nx_reg   <= nx_next;
            ny_reg   <= ny_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign sums.dot    = dot_reg;
    assign sums.norm_x = nx_reg;
    assign sums.norm_y = ny_reg;
    assign sums.count  = cnt_reg;
    assign sums.done   = done_reg;

endmodule

// ===== rtl/csim_alu.sv =====
// Shared wide adder and subtractor with a carry out used as the compare result.
`timescale 1ns / 1ps
module csim_alu (
    input  logic [csim_pkg::ALU_W-1:0] op_a,
    input  logic [csim_pkg::ALU_W-1:0] op_b,
    input  logic                       sub,
    output logic [csim_pkg::ALU_W-1:0] result,
    output logic                       carry
);
    import csim_pkg::*;

    logic [ALU_W-1:0] b_eff;

    assign b_eff = sub ? ~op_b : op_b;
    assign {carry, result} = {1'b0, op_a} + {1'b0, b_eff} + (ALU_W + 1)'(sub);

endmodule

// ===== rtl/csim_solver.sv =====
// Sequencer that turns the finished sums into the rounded similarity on the shared adder.
`timescale 1ns / 1ps
module csim_solver (
    input  logic                 clk,
    input  logic                 rst_n,
    input  csim_pkg::csim_sums_t sums,
    output logic                 take,
    output logic                 res_valid,
    input  logic                 res_ack,
    output csim_pkg::csim_res_t  res
);
    import csim_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MUL_DD = 6'b000010,
        ST_MUL_P  = 6'b000100,
        ST_DIV    = 6'b001000,
        ST_SQRT   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [ALU_W-1:0]    acc_reg, acc_next;
    logic [ALU_W-1:0]    mcand_reg, mcand_next;
    logic [MAG_W-1:0]    mplier_reg, mplier_next;
    logic [SQ_W-1:0]     dd_reg, dd_next;
    logic [SQ_W-1:0]     p_reg, p_next;
    logic [QUO_W-1:0]    q_reg, q_next;
    logic [RAD_W-1:0]    sq_reg, sq_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [NORM_W-1:0]   ny_reg, ny_next;
    logic                neg_reg, neg_next;
    logic                zero_reg, zero_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    logic [ALU_W-1:0]    alu_a;
    logic [ALU_W-1:0]    alu_b;
    logic                alu_sub;
    logic [ALU_W-1:0]    alu_sum;
    logic                alu_carry;

    logic [MAG_W-1:0]    mag;
    logic [ALU_W-1:0]    prod;
    logic [ALU_W-1:0]    rem2;
    logic [QUO_W-1:0]    quo;
    logic [ROOT_W-1:0]   m_val;
    logic [ROOT_W-1:0]   m_neg;

    csim_alu u_alu (
        .op_a   (alu_a),
        .op_b   (alu_b),
        .sub    (alu_sub),
        .result (alu_sum),
        .carry  (alu_carry)
    );

    assign mag  = sums.dot[DOT_W-1] ? MAG_W'(-sums.dot) : MAG_W'(sums.dot);
    assign prod = mplier_reg[0] ? alu_sum : acc_reg;
    assign rem2 = {acc_reg[ALU_W-2:0], q_reg[QUO_W-1]};
    assign quo  = {q_reg[QUO_W-2:0], alu_carry};

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        dd_next     = dd_reg;
        p_next      = p_reg;
        q_next      = q_reg;
        sq_next     = sq_reg;
        root_next   = root_reg;
        ny_next     = ny_reg;
        neg_next    = neg_reg;
        zero_next   = zero_reg;
        cnt_next    = cnt_reg;
        alu_a       = acc_reg;
        alu_b       = mcand_reg;
        alu_sub     = 1'b0;
        take        = 1'b0;
        res_valid   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sums.done)
                begin
                    take        = 1'b1;
                    neg_next    = sums.dot[DOT_W-1];
                    zero_next   = (sums.norm_x == '0) || (sums.norm_y == '0);
                    cnt_next    = sums.count;
                    ny_next     = sums.norm_y;
                    acc_next    = '0;
                    mcand_next  = ALU_W'(mag);
                    mplier_next = mag;
                    dd_next     = SQ_W'(sums.norm_x);
                    step_next   = STEP_W'(MUL_STEPS - 1);
                    if ((sums.norm_x == '0) || (sums.norm_y == '0))
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_MUL_DD;
                    end
                end
            end
            ST_MUL_DD:
            begin
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                if (step_reg == '0)
                begin
                    // The norm of x was parked in dd_reg until the square of the dot is ready.
                    mcand_next  = ALU_W'(dd_reg);
                    mplier_next = ny_reg;
                    dd_next     = prod[SQ_W-1:0];
                    acc_next    = '0;
                    step_next   = STEP_W'(MUL_STEPS - 1);
                    state_next  = ST_MUL_P;
                end
                else
                begin
                    acc_next  = prod;
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_MUL_P:
            begin
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                if (step_reg == '0)
                begin
                    p_next     = prod[SQ_W-1:0];
                    acc_next   = ALU_W'(dd_reg[SQ_W-1:1]);
                    q_next     = {dd_reg[0], {SCALE_SHIFT{1'b0}}};
                    step_next  = STEP_W'(DIV_STEPS - 1);
                    state_next = ST_DIV;
                end
                else
                begin
                    acc_next  = prod;
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_DIV:
            begin
                alu_a    = rem2;
                alu_b    = ALU_W'(p_reg);
                alu_sub  = 1'b1;
                acc_next = alu_carry ? alu_sum : rem2;
                q_next   = quo;
                if (step_reg == '0)
                begin
                    sq_next    = {1'b0, quo};
                    acc_next   = '0;
                    root_next  = '0;
                    step_next  = STEP_W'(SQRT_STEPS - 1);
                    state_next = ST_SQRT;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_SQRT:
            begin
                alu_a     = {acc_reg[ALU_W-3:0], sq_reg[RAD_W-1:RAD_W-2]};
                alu_b     = ALU_W'({root_reg[ROOT_W-2:0], 2'b01});
                alu_sub   = 1'b1;
                acc_next  = alu_carry ? alu_sum : alu_a;
                root_next = {root_reg[ROOT_W-2:0], alu_carry};
                sq_next   = sq_reg << 2;
                if (step_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg   <= step_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        dd_reg     <= dd_next;
        p_reg      <= p_next;
        q_reg      <= q_next;
        sq_reg     <= sq_next;
        root_reg   <= root_next;
        ny_reg     <= ny_next;
        neg_reg    <= neg_next;
        zero_reg   <= zero_next;
        cnt_reg    <= cnt_next;
    end

    // The largest odd value not above the root gives the rounded magnitude.
    assign m_val = ROOT_W'((root_reg + ROOT_W'(1)) >> 1);
    assign m_neg = ~m_val + ROOT_W'(1);

    always_comb
    begin
        res.zero_norm     = zero_reg;
        res.element_count = cnt_reg;
        if (zero_reg)
        begin
            res.similarity = '0;
        end
        else if (neg_reg)
        begin
            res.similarity = SIM_W'(m_neg);
        end
        else if (m_val > SIM_MAX)
        begin
            res.similarity = SIM_W'(SIM_MAX);
        end
        else
        begin
            res.similarity = SIM_W'(m_val);
        end
    end

endmodule

// ===== rtl/cosine_similarity_engine.sv =====
// Top level of the streaming fixed-point cosine similarity engine.
// Element pairs are taken one per cycle; after a marked last pair the input stalls until the sequencer takes the sums.
// After the transfer of the last pair the result comes from these steps, skipped when a norm is zero:
// two 43-step shift-add multiplies, a 33-step divide and a 17-step square root on one adder.
// The next vectors stream in while a result is computed; one finish runs at a time.
// Reset clears the sums, the pair count, the sequencer and the output valid flag.
`timescale 1ns / 1ps
module cosine_similarity_engine (
    input  logic        clk,
    input  logic        rst_n,
    csim_in_if.sink     elem_ch,
    csim_out_if.source  result_ch
);
    import csim_pkg::*;

    csim_sums_t              sums;
    csim_res_t               res;
    logic                    take;
    logic                    res_valid;
    logic                    res_ack;
    logic                    out_valid_reg, out_valid_next;
    logic signed [SIM_W-1:0] sim_reg;
    logic                    zero_reg;
    logic [CNT_W-1:0]        cnt_reg;

    csim_accum u_accum (
        .clk     (clk),
        .rst_n   (rst_n),
        .elem_ch (elem_ch),
        .clear   (take),
        .sums    (sums)
    );

    csim_solver u_solver (
        .clk       (clk),
        .rst_n     (rst_n),
        .sums      (sums),
        .take      (take),
        .res_valid (res_valid),
        .res_ack   (res_ack),
        .res       (res)
    );

    assign res_ack = res_valid && (!out_valid_reg || result_ch.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ack)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ack)
        begin
            sim_reg  <= res.similarity;
            zero_reg <= res.zero_norm;
            cnt_reg  <= res.element_count;
        end
    end

    assign result_ch.valid         = out_valid_reg;
    assign result_ch.similarity    = sim_reg;
    assign result_ch.zero_norm     = zero_reg;
    assign result_ch.element_count = cnt_reg;

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench of the cosine similarity engine with a built-in predictor.
`timescale 1ns / 1ps
module testbench;
    import csim_pkg::*;

    localparam int unsigned LONG_HOLD  = 1500;
    localparam int unsigned IDLE_LIMIT = 12000;
    localparam int unsigned END_WAIT   = 300;
    localparam int unsigned RANDOM_PAIRS = 780;

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] x;
        logic signed [SAMPLE_WIDTH-1:0] y;
        logic                           last;
        logic                           drain;
    } elem_pair_t;

    typedef enum int {
        VEC_INDEPENDENT,
        VEC_SAME,
        VEC_OPPOSITE,
        VEC_NOISY,
        VEC_SCALED,
        VEC_ZERO,
        VEC_EXTREME_Y
    } vec_kind_t;

    logic clk = 1'b0;
    logic rst_n;

    csim_in_if  elem_if ();
    csim_out_if res_if ();

    cosine_similarity_engine DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .elem_ch   (elem_if),
        .result_ch (res_if)
    );

    always #10 clk = ~clk;

    elem_pair_t pair_queue[$];
    csim_res_t  predicted_results[$];

    logic signed [DOT_W-1:0] dot_acc    = '0;
    logic [NORM_W-1:0]       xx_total   = '0;
    logic [NORM_W-1:0]       yy_total   = '0;
    logic [CNT_W-1:0]        pair_total = '0;

    csim_res_t   handoff_res;
    logic        handoff_valid;
    int unsigned results_due;
    int unsigned results_taken;
    int unsigned err_cnt = 0;
    int unsigned idle_cycles = 0;

    logic        took_pair;
    logic        closing;
    logic        has_res;
    csim_res_t   new_res;
    elem_pair_t  next_pair;
    int unsigned send_gap;
    logic        send_quiet;
    int unsigned send_mode_left;

    logic        took_res;
    csim_res_t   want;
    int unsigned hold_left;
    logic        recv_quiet;
    int unsigned recv_mode_left;

    int unsigned random_pairs;
    int unsigned vec_count;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        err_cnt++;
    endtask

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(12, 60);
        return $urandom_range(1, 3);
    endfunction

    // Largest m in [0, 32768] with (2m-1)^2 * nx * ny <= 2^32 * d^2.
    function automatic int unsigned round_cos_mag(input logic [NORM_W-1:0] d,
                                                  input logic [NORM_W-1:0] nx,
                                                  input logic [NORM_W-1:0] ny);
        logic [127:0] norm_prod;
        logic [127:0] bound;
        logic [127:0] lhs;
        logic [63:0]  odd;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        norm_prod = 128'(nx) * 128'(ny);
        bound = (128'(d) * 128'(d)) << 32;
        lo = 0;
        hi = 32768;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            odd = 64'(2 * mid - 1);
            lhs = norm_prod * 128'(odd * odd);
            if (lhs <= bound)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    task automatic fold_pair(input logic signed [SAMPLE_WIDTH-1:0] x,
                             input logic signed [SAMPLE_WIDTH-1:0] y,
                             input logic last,
                             output logic produced,
                             output csim_res_t res);
        logic signed [DOT_W-1:0] xs;
        logic signed [DOT_W-1:0] ys;
        logic [DOT_W-1:0]        mag_dot;
        int unsigned             m;
        xs = x;
        ys = y;
        produced = last;
        res = '0;
        if (pair_total < MAX_LEN)
        begin
            dot_acc    = dot_acc + xs * ys;
            xx_total   = xx_total + NORM_W'(xs * xs);
            yy_total   = yy_total + NORM_W'(ys * ys);
            pair_total = pair_total + 1'b1;
        end
        if (last)
        begin
            res.element_count = pair_total;
            if (xx_total == '0 || yy_total == '0)
            begin
                res.zero_norm  = 1'b1;
                res.similarity = '0;
            end
            else
            begin
                mag_dot = (dot_acc < 0) ? -dot_acc : dot_acc;
                m = round_cos_mag(NORM_W'(mag_dot), xx_total, yy_total);
                if (dot_acc < 0)
                    res.similarity = -SIM_W'(m);
                else
                    res.similarity = (m > 32767) ? 16'sd32767 : SIM_W'(m);
            end
            dot_acc    = '0;
            xx_total   = '0;
            yy_total   = '0;
            pair_total = '0;
        end
    endtask

    task automatic add_pair(input logic signed [SAMPLE_WIDTH-1:0] x,
                            input logic signed [SAMPLE_WIDTH-1:0] y,
                            input logic last, input logic drain);
        elem_pair_t p;
        p.x = x;
        p.y = y;
        p.last = last;
        p.drain = drain;
        pair_queue.push_back(p);
    endtask

    function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
        logic signed [SAMPLE_WIDTH-1:0] s;
        case ($urandom_range(0, 7))
            0: s = -16'sd32768;
            1: s = 16'sd32767;
            2: s = '0;
            3:
            begin
                s = SAMPLE_WIDTH'($urandom_range(0, 16));
                s = s - 16'sd8;
            end
            default: s = SAMPLE_WIDTH'($urandom);
        endcase
        return s;
    endfunction

    task automatic add_random_vector(input logic drain);
        vec_kind_t kind;
        int unsigned len;
        int unsigned pick;
        int unsigned shift;
        logic signed [SAMPLE_WIDTH-1:0] x;
        logic signed [SAMPLE_WIDTH-1:0] y;
        logic signed [SAMPLE_WIDTH-1:0] noise;
        kind = vec_kind_t'($urandom_range(0, 6));
        pick = $urandom_range(0, 99);
        if (pick < 75)
            len = $urandom_range(1, 6);
        else if (pick < 97)
            len = $urandom_range(7, 24);
        else
            len = $urandom_range(25, 200);
        shift = $urandom_range(0, 4);
        for (int unsigned i = 0; i < len; i++)
        begin
            x = rand_sample();
            noise = SAMPLE_WIDTH'($urandom_range(0, 6));
            noise = noise - 16'sd3;
            case (kind)
                VEC_SAME:      y = x;
                VEC_OPPOSITE:  y = -x;
                VEC_NOISY:     y = x + noise;
                VEC_SCALED:    y = x >>> shift;
                VEC_ZERO:
                begin
                    if (shift[0])
                        x = '0;
                    y = shift[0] ? rand_sample() : '0;
                end
                VEC_EXTREME_Y: y = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
                default:       y = rand_sample();
            endcase
            add_pair(x, y, i == len - 1, drain && i == 0);
        end
        random_pairs += len;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_if.valid     <= 1'b0;
            elem_if.x_elem    <= '0;
            elem_if.y_elem    <= '0;
            elem_if.last_elem <= 1'b0;
            send_gap          <= 0;
            send_quiet        <= 1'b0;
            send_mode_left    <= 0;
            handoff_valid     <= 1'b0;
            handoff_res       <= '0;
            results_due       <= 0;
        end
        else
        begin
            took_pair = elem_if.valid && elem_if.ready;
            closing = took_pair && elem_if.last_elem;
            has_res = 1'b0;
            new_res = '0;
            if (took_pair)
                fold_pair(elem_if.x_elem, elem_if.y_elem, elem_if.last_elem, has_res, new_res);
            handoff_valid <= has_res;
            handoff_res   <= new_res;
            if (has_res)
                results_due <= results_due + 1;

            if (send_mode_left == 0)
            begin
                send_quiet     <= ($urandom_range(0, 2) == 0);
                send_mode_left <= $urandom_range(100, 400);
            end
            else
                send_mode_left <= send_mode_left - 1;

            if (!(elem_if.valid && !elem_if.ready))
            begin
                if (send_gap != 0)
                begin
                    send_gap      <= send_gap - 1;
                    elem_if.valid <= 1'b0;
                end
                else if (pair_queue.size() != 0 &&
                         !(pair_queue[0].drain && (closing || results_due != results_taken)))
                begin
                    next_pair = pair_queue.pop_front();
                    elem_if.x_elem    <= next_pair.x;
                    elem_if.y_elem    <= next_pair.y;
                    elem_if.last_elem <= next_pair.last;
                    elem_if.valid     <= 1'b1;
                    send_gap <= (send_quiet || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
                end
                else
                    elem_if.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready   <= 1'b0;
            hold_left      <= 0;
            recv_quiet     <= 1'b0;
            recv_mode_left <= 0;
            results_taken  <= 0;
        end
        else
        begin
            if (handoff_valid)
                predicted_results.push_back(handoff_res);
            took_res = res_if.valid && res_if.ready;
            if (took_res)
            begin
                results_taken <= results_taken + 1;
                if (predicted_results.size() == 0)
                    report_mismatch($sformatf("result with nothing expected, similarity %0d",
                                              res_if.similarity));
                else
                begin
                    want = predicted_results.pop_front();
                    if (res_if.similarity !== want.similarity)
                        report_mismatch($sformatf("similarity %0d, expected %0d",
                                                  res_if.similarity, want.similarity));
                    if (res_if.zero_norm !== want.zero_norm)
                        report_mismatch($sformatf("zero_norm %0b, expected %0b",
                                                  res_if.zero_norm, want.zero_norm));
                    if (res_if.element_count !== want.element_count)
                        report_mismatch($sformatf("element_count %0d, expected %0d",
                                                  res_if.element_count, want.element_count));
                end
            end

            if (recv_mode_left == 0)
            begin
                recv_quiet     <= ($urandom_range(0, 2) == 0);
                recv_mode_left <= $urandom_range(100, 400);
            end
            else
                recv_mode_left <= recv_mode_left - 1;

            if (hold_left != 0)
            begin
                hold_left    <= hold_left - 1;
                res_if.ready <= 1'b0;
            end
            else if (took_res && (results_taken == 20 || results_taken == 60))
            begin
                hold_left    <= LONG_HOLD;
                res_if.ready <= 1'b0;
            end
            else if (!recv_quiet && $urandom_range(0, 3) == 0)
            begin
                hold_left    <= pick_gap();
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((elem_if.valid && elem_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("no transfer for %0d cycles", idle_cycles);
                $display("FAILURE");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        rst_n = 1'b0;

        add_pair(16'sd32767, 16'sd32767, 1'b1, 1'b0);
        add_pair(-16'sd32768, -16'sd32768, 1'b1, 1'b0);
        add_pair(-16'sd32768, 16'sd32767, 1'b1, 1'b0);
        add_pair(16'sd32767, -16'sd32768, 1'b1, 1'b0);
        add_pair(16'sd0, 16'sd12345, 1'b1, 1'b0);
        add_pair(-16'sd7, 16'sd0, 1'b1, 1'b0);
        add_pair(16'sd0, 16'sd0, 1'b1, 1'b0);
        add_pair(16'sd1, 16'sd0, 1'b0, 1'b0);
        add_pair(16'sd0, 16'sd1, 1'b1, 1'b0);
        add_pair(16'sd3, 16'sd4, 1'b0, 1'b0);
        add_pair(16'sd4, -16'sd3, 1'b0, 1'b0);
        add_pair(16'sd1, 16'sd1, 1'b1, 1'b0);
        add_pair(16'sd0, 16'sd0, 1'b0, 1'b0);
        add_pair(16'sd0, 16'sd0, 1'b0, 1'b0);
        add_pair(16'sd5, -16'sd5, 1'b1, 1'b0);
        add_pair(16'sd1, 16'sd2, 1'b0, 1'b0);
        add_pair(16'sd2, 16'sd1, 1'b1, 1'b0);
        add_pair(16'sd32767, -16'sd1, 1'b1, 1'b0);

        random_pairs = 0;
        vec_count = 0;
        while (random_pairs < RANDOM_PAIRS)
        begin
            add_random_vector(vec_count == 10 || $urandom_range(0, 29) == 0);
            vec_count++;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pair_queue.size() != 0 || elem_if.valid || results_due != results_taken)
            @(posedge clk);
        repeat (END_WAIT) @(posedge clk);

        if (predicted_results.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      predicted_results.size()));
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
